FILE: sv/epsm_pkg.sv
// Shared types, constants and the path-pattern table of the element path suffix matcher.
package epsm_pkg;

  localparam int STACK_DEPTH  = 24;
  localparam int CNT_W        = $clog2(STACK_DEPTH + 1);
  localparam int CODE_W       = 6;
  localparam int CTX_W        = 6;
  localparam int DEPTH_W      = 5;
  localparam int NUM_ELEMENTS = 59;
  localparam int NUM_PATTERNS = 46;
  localparam int MAX_PAT_LEN  = 4;

  typedef enum logic [1:0] {
    CMD_BEGIN = 2'd0,
    CMD_START = 2'd1,
    CMD_END   = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ERR_OK    = 2'd0,
    ERR_LIMIT = 2'd1,
    ERR_UNDER = 2'd2,
    ERR_RSVD  = 2'd3
  } err_t;

  typedef enum logic {
    KIND_START = 1'b0,
    KIND_END   = 1'b1
  } kind_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic  clear;
    logic  push;
    logic  pop;
    logic  capture;
    kind_t kind;
    err_t  err;
  } epsm_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic full;
    logic empty;
  } epsm_stat_t;

  // Element codes used by the pattern table.
  localparam logic [CODE_W-1:0] EL_CERT        = 6'd0;
  localparam logic [CODE_W-1:0] EL_CERTCHAIN   = 6'd1;
  localparam logic [CODE_W-1:0] EL_CIPHERDATA  = 6'd2;
  localparam logic [CODE_W-1:0] EL_CIPHERVALUE = 6'd3;
  localparam logic [CODE_W-1:0] EL_CONTENTID   = 6'd4;
  localparam logic [CODE_W-1:0] EL_DEVDETAILS  = 6'd6;
  localparam logic [CODE_W-1:0] EL_DEVID       = 6'd7;
  localparam logic [CODE_W-1:0] EL_DIGESTVAL   = 6'd8;
  localparam logic [CODE_W-1:0] EL_DN          = 6'd9;
  localparam logic [CODE_W-1:0] EL_DOMALIAS    = 6'd10;
  localparam logic [CODE_W-1:0] EL_DOMID       = 6'd11;
  localparam logic [CODE_W-1:0] EL_DOMINFO     = 6'd12;
  localparam logic [CODE_W-1:0] EL_DOMKEY      = 6'd13;
  localparam logic [CODE_W-1:0] EL_ENCKEY      = 6'd14;
  localparam logic [CODE_W-1:0] EL_ENCMETHOD   = 6'd15;
  localparam logic [CODE_W-1:0] EL_EXT         = 6'd16;
  localparam logic [CODE_W-1:0] EL_EXTS        = 6'd17;
  localparam logic [CODE_W-1:0] EL_HASH        = 6'd18;
  localparam logic [CODE_W-1:0] EL_ID          = 6'd19;
  localparam logic [CODE_W-1:0] EL_IDENT       = 6'd20;
  localparam logic [CODE_W-1:0] EL_JOIN        = 6'd21;
  localparam logic [CODE_W-1:0] EL_JOINRESP    = 6'd22;
  localparam logic [CODE_W-1:0] EL_KEYID       = 6'd23;
  localparam logic [CODE_W-1:0] EL_LEAVE       = 6'd24;
  localparam logic [CODE_W-1:0] EL_LEAVERESP   = 6'd25;
  localparam logic [CODE_W-1:0] EL_MAC         = 6'd26;
  localparam logic [CODE_W-1:0] EL_NONCE       = 6'd29;
  localparam logic [CODE_W-1:0] EL_NOTAFTER    = 6'd30;
  localparam logic [CODE_W-1:0] EL_OCSP        = 6'd31;
  localparam logic [CODE_W-1:0] EL_REGREQ      = 6'd33;
  localparam logic [CODE_W-1:0] EL_REGRESP     = 6'd34;
  localparam logic [CODE_W-1:0] EL_RIALIAS     = 6'd35;
  localparam logic [CODE_W-1:0] EL_RIHELLO     = 6'd37;
  localparam logic [CODE_W-1:0] EL_RIID        = 6'd38;
  localparam logic [CODE_W-1:0] EL_RINONCE     = 6'd39;
  localparam logic [CODE_W-1:0] EL_RIURL       = 6'd40;
  localparam logic [CODE_W-1:0] EL_ROACQ       = 6'd42;
  localparam logic [CODE_W-1:0] EL_TRIGGER     = 6'd43;
  localparam logic [CODE_W-1:0] EL_ROAPURL     = 6'd44;
  localparam logic [CODE_W-1:0] EL_ROID        = 6'd45;
  localparam logic [CODE_W-1:0] EL_RORESP      = 6'd47;
  localparam logic [CODE_W-1:0] EL_SELALG      = 6'd48;
  localparam logic [CODE_W-1:0] EL_SELVER      = 6'd49;
  localparam logic [CODE_W-1:0] EL_SERVINFO    = 6'd50;
  localparam logic [CODE_W-1:0] EL_SIG         = 6'd51;
  localparam logic [CODE_W-1:0] EL_SIGVAL      = 6'd52;
  localparam logic [CODE_W-1:0] EL_SUPALG      = 6'd53;
  localparam logic [CODE_W-1:0] EL_TRUSTAUTH   = 6'd56;
  localparam logic [CODE_W-1:0] EL_NONE        = 6'd0;

  // One path pattern; e0 is the innermost element.
  typedef struct packed {
    logic [2:0]        len;
    logic [CODE_W-1:0] e0;
    logic [CODE_W-1:0] e1;
    logic [CODE_W-1:0] e2;
    logic [CODE_W-1:0] e3;
  } pattern_t;

  // Pattern i gives context code i + 1. Longest patterns come first.
  localparam pattern_t PATTERNS [NUM_PATTERNS] = '{
    '{3'd4, EL_HASH,        EL_KEYID,      EL_RIID,       EL_RORESP},
    '{3'd4, EL_HASH,        EL_KEYID,      EL_RIID,       EL_JOINRESP},
    '{3'd3, EL_HASH,        EL_KEYID,      EL_DEVID,      EL_NONE},
    '{3'd3, EL_HASH,        EL_KEYID,      EL_TRUSTAUTH,  EL_NONE},
    '{3'd3, EL_IDENT,       EL_EXT,        EL_EXTS,       EL_NONE},
    '{3'd3, EL_ID,          EL_EXT,        EL_EXTS,       EL_NONE},
    '{3'd3, EL_CONTENTID,   EL_EXT,        EL_EXTS,       EL_NONE},
    '{3'd3, EL_DN,          EL_EXT,        EL_EXTS,       EL_NONE},
    '{3'd3, EL_DEVDETAILS,  EL_EXTS,       EL_RIHELLO,    EL_NONE},
    '{3'd3, EL_HASH,        EL_KEYID,      EL_RIID,       EL_NONE},
    '{3'd3, EL_CIPHERVALUE, EL_CIPHERDATA, EL_ENCKEY,     EL_NONE},
    '{3'd3, EL_ENCMETHOD,   EL_ENCKEY,     EL_DOMKEY,     EL_NONE},
    '{3'd3, EL_MAC,         EL_DOMKEY,     EL_DOMINFO,    EL_NONE},
    '{3'd2, EL_ENCKEY,      EL_DOMKEY,     EL_NONE,       EL_NONE},
    '{3'd2, EL_CERT,        EL_CERTCHAIN,  EL_NONE,       EL_NONE},
    '{3'd2, EL_SIG,         EL_RORESP,     EL_NONE,       EL_NONE},
    '{3'd2, EL_EXT,         EL_EXTS,       EL_NONE,       EL_NONE},
    '{3'd1, EL_RIALIAS,     EL_NONE,       EL_NONE,       EL_NONE},
    '{3'd1, EL_DOMALIAS,    EL_NONE,       EL_NONE,       EL_NONE},
    '{3'd1, EL_RIHELLO,     EL_NONE,       EL_NONE,       EL_NONE},
    '{3'd1, EL_SELVER,      EL_NONE,       EL_NONE,       EL_NONE},
    '{3'd1, EL_RINONCE,     EL_NONE,       EL_NONE,       EL_NONE},
    '{3'd1, EL_OCSP,        EL_NONE,       EL_NONE,       EL_NONE},
    '{3'd1, EL_RIURL,       EL_NONE,       EL_NONE,       EL_NONE},
    '{3'd1, EL_SIG,         EL_NONE,       EL_NONE,       EL_NONE},
    '{3'd1, EL_REGRESP,     EL_NONE,       EL_NONE,       EL_NONE},
    '{3'd1, EL_RORESP,      EL_NONE,       EL_NONE,       EL_NONE},
    '{3'd1, EL_JOINRESP,    EL_NONE,       EL_NONE,       EL_NONE},
    '{3'd1, EL_LEAVERESP,   EL_NONE,       EL_NONE,       EL_NONE},
    '{3'd1, EL_DOMID,       EL_NONE,       EL_NONE,       EL_NONE},
    '{3'd1, EL_NONCE,       EL_NONE,       EL_NONE,       EL_NONE},
    '{3'd1, EL_NOTAFTER,    EL_NONE,       EL_NONE,       EL_NONE},
    '{3'd1, EL_DOMKEY,      EL_NONE,       EL_NONE,       EL_NONE},
    '{3'd1, EL_TRIGGER,     EL_NONE,       EL_NONE,       EL_NONE},
    '{3'd1, EL_ROAPURL,     EL_NONE,       EL_NONE,       EL_NONE},
    '{3'd1, EL_REGREQ,      EL_NONE,       EL_NONE,       EL_NONE},
    '{3'd1, EL_ROACQ,       EL_NONE,       EL_NONE,       EL_NONE},
    '{3'd1, EL_JOIN,        EL_NONE,       EL_NONE,       EL_NONE},
    '{3'd1, EL_LEAVE,       EL_NONE,       EL_NONE,       EL_NONE},
    '{3'd1, EL_ROID,        EL_NONE,       EL_NONE,       EL_NONE},
    '{3'd1, EL_CONTENTID,   EL_NONE,       EL_NONE,       EL_NONE},
    '{3'd1, EL_SIGVAL,      EL_NONE,       EL_NONE,       EL_NONE},
    '{3'd1, EL_DIGESTVAL,   EL_NONE,       EL_NONE,       EL_NONE},
    '{3'd1, EL_SERVINFO,    EL_NONE,       EL_NONE,       EL_NONE},
    '{3'd1, EL_SUPALG,      EL_NONE,       EL_NONE,       EL_NONE},
    '{3'd1, EL_SELALG,      EL_NONE,       EL_NONE,       EL_NONE}
  };

  // Returns the context code for the given top-of-stack entries (index 0 is the top)
  // and stack depth. All patterns are compared in parallel; the lowest index wins.
  function automatic logic [CTX_W-1:0] match_context(
    input logic [MAX_PAT_LEN-1:0][CODE_W-1:0] top,
    input logic [CNT_W-1:0]                   depth
  );
    logic [CTX_W-1:0]                   ctx;
    logic                               ok;
    logic [MAX_PAT_LEN-1:0][CODE_W-1:0] pat;
    ctx = '0;
    for (int i = NUM_PATTERNS - 1; i >= 0; i--) begin
      pat = {PATTERNS[i].e3, PATTERNS[i].e2, PATTERNS[i].e1, PATTERNS[i].e0};
      ok  = 1'b1;
      for (int k = 0; k < MAX_PAT_LEN; k++) begin
        if ((k < int'(PATTERNS[i].len)) && (k < int'(depth)) && (top[k] != pat[k])) begin
          ok = 1'b0;
        end
      end
      if (ok) begin
        ctx = CTX_W'(i + 1);
      end
    end
    if (depth == '0) begin
      ctx = '0;
    end
    return ctx;
  endfunction

endpackage

FILE: sv/element_path_suffix_matcher.sv
// Top level of the element path suffix matcher.
//
// This block follows a stream of tokenized XML tag events and, for each start
// or end tag of a recognized element, reports which entry of a fixed table of
// element paths describes the current nesting. Each input beat carries a command
// in s_tuser (begin document, start element, end element) and an element code
// in s_tdata. A begin beat empties the stack and clears the error hold; it gives
// no output. A start beat pushes the element and then reports; an end beat
// reports and then pops. The reported context is the first table pattern,
// longest first, whose path matches the top of the stack, with only as many
// entries compared as the stack is deep. Unrecognized element codes and the
// unused command value are dropped without a result. When a start brings the
// stack to its limit of 24 entries, or an end arrives on an empty stack, the
// result carries an error code and all later start and end beats are ignored
// until the next begin. For a beat that produces a result, the push happens at
// the accepting edge, the match against the top four stack entries runs in the
// following cycle and is loaded into the output register at the next edge, so
// m_tvalid rises with that load and then holds for as long as m_tready stays
// low. s_tready stays low until the result is taken, so the block accepts no
// new beat while a result is pending; a beat without a result leaves s_tready
// high. The stack is a shift register, so the top four entries feed the
// parallel pattern compare directly and no clearing pass is needed after reset.
module element_path_suffix_matcher import epsm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [5:0] element_code, [7:6] zero
  input  logic [1:0]  s_tuser,   // [1:0] command
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [5:0] context_code, [10:6] nest_depth,
                                 // [12:11] error_code, [15:13] zero
  output logic [0:0]  m_tuser    // [0] event_kind
);

  epsm_cmd_t          cmd;
  epsm_stat_t         stat;
  kind_t              event_kind;
  logic [CTX_W-1:0]   context_code;
  logic [DEPTH_W-1:0] nest_depth;
  err_t               error_code;

  epsm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_cmd    (cmd_t'(s_tuser)),
    .in_code   (s_tdata[CODE_W-1:0]),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  epsm_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .in_code      (s_tdata[CODE_W-1:0]),
    .stat         (stat),
    .event_kind   (event_kind),
    .context_code (context_code),
    .nest_depth   (nest_depth),
    .error_code   (error_code)
  );

  // The two upper input bits are padding and are not used.
  assign m_tdata = {3'b000, error_code, nest_depth, context_code};
  assign m_tuser = event_kind;

endmodule

FILE: sv/epsm_ctrl.sv
// Controller state machine of the element path suffix matcher.
module epsm_ctrl import epsm_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  cmd_t              in_cmd,
  input  logic [CODE_W-1:0] in_code,
  output logic              out_valid,
  input  logic              out_ready,
  input  epsm_stat_t        stat,
  output epsm_cmd_t         cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MATCH,
    ST_OUT
  } state_t;

  state_t state;
  logic   halted;
  kind_t  kind;
  logic   accept;
  logic   event_ok;

  assign in_ready  = (state == ST_IDLE);
  assign out_valid = (state == ST_OUT);
  assign accept    = in_valid && in_ready;
  assign event_ok  = !halted && (in_code < CODE_W'(NUM_ELEMENTS));

  always_comb begin
    cmd = '{clear: 1'b0, push: 1'b0, pop: 1'b0, capture: 1'b0,
            kind: kind, err: ERR_OK};
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (in_cmd == CMD_BEGIN) begin
            cmd.clear = 1'b1;
          end else if (in_cmd == CMD_START && event_ok && !stat.full) begin
            cmd.push = 1'b1;
          end
        end
      end
      ST_MATCH: begin
        cmd.capture = 1'b1;
        if (kind == KIND_START) begin
          cmd.err = stat.full ? ERR_LIMIT : ERR_OK;
        end else if (stat.empty) begin
          cmd.err = ERR_UNDER;
        end else begin
          cmd.pop = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      halted <= 1'b0;
      kind   <= KIND_START;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            case (in_cmd)
              CMD_BEGIN: begin
                halted <= 1'b0;
              end
              CMD_START: begin
                if (event_ok) begin
                  if (stat.full) begin
                    halted <= 1'b1;
                  end else begin
                    kind  <= KIND_START;
                    state <= ST_MATCH;
                  end
                end
              end
              CMD_END: begin
                if (event_ok) begin
                  kind  <= KIND_END;
                  state <= ST_MATCH;
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_MATCH: begin
          if (kind == KIND_START) begin
            halted <= stat.full;
          end else if (stat.empty) begin
            halted <= 1'b1;
          end
          state <= ST_OUT;
        end
        ST_OUT: begin
          if (out_ready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: sv/epsm_dp.sv
// Datapath of the element path suffix matcher: shift-register stack, matcher and result register.
module epsm_dp import epsm_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  epsm_cmd_t          cmd,
  input  logic [CODE_W-1:0]  in_code,
  output epsm_stat_t         stat,
  output kind_t              event_kind,
  output logic [CTX_W-1:0]   context_code,
  output logic [DEPTH_W-1:0] nest_depth,
  output err_t               error_code
);

  // Entry 0 is the top of the stack, so the matcher reads fixed taps.
  logic [CODE_W-1:0]                  stack [STACK_DEPTH];
  logic [CNT_W-1:0]                   count;
  logic [MAX_PAT_LEN-1:0][CODE_W-1:0] top;
  logic [CTX_W-1:0]                   ctx;

  assign stat.full  = (count == CNT_W'(STACK_DEPTH));
  assign stat.empty = (count == '0);

  always_comb begin
    for (int k = 0; k < MAX_PAT_LEN; k++) begin
      top[k] = stack[k];
    end
  end

  assign ctx = match_context(top, count);

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      stack[0] <= in_code;
      for (int i = 1; i < STACK_DEPTH; i++) begin
        stack[i] <= stack[i-1];
      end
    end else if (cmd.pop) begin
      for (int i = 0; i < STACK_DEPTH - 1; i++) begin
        stack[i] <= stack[i+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.clear) begin
      count <= '0;
    end else if (cmd.push) begin
      count <= count + 1'b1;
    end else if (cmd.pop) begin
      count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      event_kind   <= cmd.kind;
      context_code <= ctx;
      nest_depth   <= DEPTH_W'(count);
      error_code   <= cmd.err;
    end
  end

endmodule

FILE: tb/tb.sv
// Self-checking testbench for the element path suffix matcher stream block.
`timescale 1ns / 1ps

module tb;
  import epsm_pkg::*;

  localparam int STALL_LIMIT  = 2000;  // cycles without any handshake before giving up
  localparam int SETTLE_TICKS = 8;     // margin after the last report has come back
  localparam int RANDOM_ITEMS = 1330;

  // One reported tag event, as the output port carries it.
  typedef struct packed {
    kind_t              kind;
    logic [CTX_W-1:0]   ctx;
    logic [DEPTH_W-1:0] depth;
    err_t               err;
  } context_report_t;

  typedef enum int {
    RDY_ALWAYS,
    RDY_MOSTLY,
    RDY_RARELY,
    RDY_TOGGLE
  } ready_mode_t;

  localparam logic [CODE_W-1:0] NO_EL = '0;

  // Path table, innermost element first; pattern i yields context code i + 1.
  localparam logic [MAX_PAT_LEN*CODE_W-1:0] SUFFIX_PATH [NUM_PATTERNS] = '{
    {EL_HASH,        EL_KEYID,      EL_RIID,      EL_RORESP},
    {EL_HASH,        EL_KEYID,      EL_RIID,      EL_JOINRESP},
    {EL_HASH,        EL_KEYID,      EL_DEVID,     NO_EL},
    {EL_HASH,        EL_KEYID,      EL_TRUSTAUTH, NO_EL},
    {EL_IDENT,       EL_EXT,        EL_EXTS,      NO_EL},
    {EL_ID,          EL_EXT,        EL_EXTS,      NO_EL},
    {EL_CONTENTID,   EL_EXT,        EL_EXTS,      NO_EL},
    {EL_DN,          EL_EXT,        EL_EXTS,      NO_EL},
    {EL_DEVDETAILS,  EL_EXTS,       EL_RIHELLO,   NO_EL},
    {EL_HASH,        EL_KEYID,      EL_RIID,      NO_EL},
    {EL_CIPHERVALUE, EL_CIPHERDATA, EL_ENCKEY,    NO_EL},
    {EL_ENCMETHOD,   EL_ENCKEY,     EL_DOMKEY,    NO_EL},
    {EL_MAC,         EL_DOMKEY,     EL_DOMINFO,   NO_EL},
    {EL_ENCKEY,      EL_DOMKEY,     NO_EL,        NO_EL},
    {EL_CERT,        EL_CERTCHAIN,  NO_EL,        NO_EL},
    {EL_SIG,         EL_RORESP,     NO_EL,        NO_EL},
    {EL_EXT,         EL_EXTS,       NO_EL,        NO_EL},
    {EL_RIALIAS,     NO_EL, NO_EL, NO_EL},
    {EL_DOMALIAS,    NO_EL, NO_EL, NO_EL},
    {EL_RIHELLO,     NO_EL, NO_EL, NO_EL},
    {EL_SELVER,      NO_EL, NO_EL, NO_EL},
    {EL_RINONCE,     NO_EL, NO_EL, NO_EL},
    {EL_OCSP,        NO_EL, NO_EL, NO_EL},
    {EL_RIURL,       NO_EL, NO_EL, NO_EL},
    {EL_SIG,         NO_EL, NO_EL, NO_EL},
    {EL_REGRESP,     NO_EL, NO_EL, NO_EL},
    {EL_RORESP,      NO_EL, NO_EL, NO_EL},
    {EL_JOINRESP,    NO_EL, NO_EL, NO_EL},
    {EL_LEAVERESP,   NO_EL, NO_EL, NO_EL},
    {EL_DOMID,       NO_EL, NO_EL, NO_EL},
    {EL_NONCE,       NO_EL, NO_EL, NO_EL},
    {EL_NOTAFTER,    NO_EL, NO_EL, NO_EL},
    {EL_DOMKEY,      NO_EL, NO_EL, NO_EL},
    {EL_TRIGGER,     NO_EL, NO_EL, NO_EL},
    {EL_ROAPURL,     NO_EL, NO_EL, NO_EL},
    {EL_REGREQ,      NO_EL, NO_EL, NO_EL},
    {EL_ROACQ,       NO_EL, NO_EL, NO_EL},
    {EL_JOIN,        NO_EL, NO_EL, NO_EL},
    {EL_LEAVE,       NO_EL, NO_EL, NO_EL},
    {EL_ROID,        NO_EL, NO_EL, NO_EL},
    {EL_CONTENTID,   NO_EL, NO_EL, NO_EL},
    {EL_SIGVAL,      NO_EL, NO_EL, NO_EL},
    {EL_DIGESTVAL,   NO_EL, NO_EL, NO_EL},
    {EL_SERVINFO,    NO_EL, NO_EL, NO_EL},
    {EL_SUPALG,      NO_EL, NO_EL, NO_EL},
    {EL_SELALG,      NO_EL, NO_EL, NO_EL}
  };

  localparam int SUFFIX_LEN [NUM_PATTERNS] = '{
    4, 4, 3, 3, 3, 3, 3, 3, 3, 3, 3, 3, 3, 2, 2, 2, 2,
    1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1
  };

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;   // [5:0] element_code, [7:6] zero
  logic [1:0]  s_tuser;   // [1:0] command
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;   // [5:0] context_code, [10:6] nest_depth, [12:11] error_code
  logic [0:0]  m_tuser;   // [0] event_kind

  // Mirror of the block's state: open elements, depth and the error hold.
  logic [CODE_W-1:0] open_elems [STACK_DEPTH];
  int                open_depth;
  bit                doc_halted;

  context_report_t expected_reports [$];
  int              fail_count;
  int              fed_items;   // input beats accepted by the block, dropped ones included
  int              burst_left;

  always #5 clk = ~clk;

  element_path_suffix_matcher i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  function automatic logic [CODE_W-1:0] path_entry(input int pat, input int k);
    return SUFFIX_PATH[pat][(MAX_PAT_LEN-1-k)*CODE_W +: CODE_W];
  endfunction

  // First pattern, longest first, whose path matches the top of the stack.
  // A stack shallower than the pattern compares only as many entries as it holds.
  function automatic logic [CTX_W-1:0] suffix_context();
    int n;
    bit hit;
    if (open_depth == 0) return '0;
    for (int i = 0; i < NUM_PATTERNS; i++) begin
      n   = (SUFFIX_LEN[i] < open_depth) ? SUFFIX_LEN[i] : open_depth;
      hit = 1'b1;
      for (int k = 0; k < n; k++) begin
        if (open_elems[open_depth-1-k] != path_entry(i, k)) hit = 1'b0;
      end
      if (hit) return CTX_W'(i + 1);
    end
    return '0;
  endfunction

  // Advances the mirror by one accepted beat and queues the report it causes.
  // Returns whether the beat did anything at all.
  function automatic bit predict_report(input cmd_t cmd, input logic [CODE_W-1:0] code);
    context_report_t rep;
    if (cmd == CMD_BEGIN) begin
      open_depth = 0;
      doc_halted = 1'b0;
      return 1'b1;
    end
    if (cmd == CMD_NONE || doc_halted || code >= NUM_ELEMENTS) return 1'b0;
    if (cmd == CMD_START) begin
      open_elems[open_depth] = code;
      open_depth++;
      rep.kind  = KIND_START;
      rep.ctx   = suffix_context();
      rep.depth = DEPTH_W'(open_depth);
      rep.err   = ERR_OK;
      if (open_depth == STACK_DEPTH) begin
        rep.err    = ERR_LIMIT;
        doc_halted = 1'b1;
      end
    end else begin
      // The end tag is reported against the stack before it is popped.
      rep.kind  = KIND_END;
      rep.ctx   = suffix_context();
      rep.depth = DEPTH_W'(open_depth);
      rep.err   = ERR_OK;
      if (open_depth == 0) begin
        rep.err    = ERR_UNDER;
        doc_halted = 1'b1;
      end else begin
        open_depth--;
      end
    end
    expected_reports.push_back(rep);
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    fail_count++;
    if (fail_count <= 100) begin
      $display("%0t ERROR %s: got %0d, expected %0d", $time, what, got, want);
    end
  endtask

  // Sends one beat. The sender runs in bursts; between bursts valid usually drops
  // for a random stretch while the data lines carry junk.
  task automatic send_beat(input cmd_t cmd, input logic [CODE_W-1:0] code);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk);
        s_tvalid = 1'b0;
        s_tuser  = 2'($urandom_range(0, 3));
        s_tdata  = {2'b00, 6'($urandom_range(0, 63))};
        repeat (gap - 1) @(negedge clk);
      end
    end
    @(negedge clk);
    s_tvalid = 1'b1;
    s_tuser  = cmd;
    s_tdata  = {2'b00, code};
    do @(posedge clk); while (!s_tready);
    burst_left--;
    void'(predict_report(cmd, code));
    fed_items++;
  endtask

  // Holds the sender off until every queued report has come back.
  task automatic wait_for_reports();
    @(negedge clk);
    s_tvalid   = 1'b0;
    burst_left = 0;
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);
  endtask

  function automatic logic [CODE_W-1:0] random_element();
    int p;
    // Half the time pick an element that the table knows, so paths match often.
    if ($urandom_range(0, 1) == 0) begin
      p = $urandom_range(0, NUM_PATTERNS - 1);
      return path_entry(p, $urandom_range(0, SUFFIX_LEN[p] - 1));
    end
    return CODE_W'($urandom_range(0, NUM_ELEMENTS - 1));
  endfunction

  // Opens the path of a random pattern, outermost first; now and then one
  // element is swapped for a random one to produce a near miss.
  task automatic push_pattern();
    int p;
    int bad;
    logic [CODE_W-1:0] code;
    p   = $urandom_range(0, NUM_PATTERNS - 1);
    bad = ($urandom_range(0, 4) == 0) ? $urandom_range(0, SUFFIX_LEN[p] - 1) : -1;
    for (int k = SUFFIX_LEN[p] - 1; k >= 0; k--) begin
      code = (k == bad) ? random_element() : path_entry(p, k);
      if (!doc_halted) send_beat(CMD_START, code);
    end
  endtask

  // Beats that the block drops: the unused command or an unknown element.
  task automatic send_noise();
    if ($urandom_range(0, 2) == 0) begin
      send_beat(CMD_NONE, CODE_W'($urandom_range(0, 63)));
    end else begin
      send_beat($urandom_range(0, 1) ? CMD_START : CMD_END,
                CODE_W'($urandom_range(NUM_ELEMENTS, 63)));
    end
  endtask

  // One document: a begin, then nested tags. Most documents are well formed;
  // some dive to the nesting limit, some pop past empty, some are left open.
  task automatic run_document();
    int steps;
    int r;
    send_beat(CMD_BEGIN, CODE_W'($urandom_range(0, 63)));
    if ($urandom_range(0, 7) == 0) begin
      while (!doc_halted) begin
        if ($urandom_range(0, 2) == 0) push_pattern();
        else send_beat(CMD_START, random_element());
      end
      // The hold must swallow these.
      send_beat(CMD_START, random_element());
      send_beat(CMD_END, random_element());
    end else begin
      steps = $urandom_range(4, 40);
      repeat (steps) begin
        r = $urandom_range(0, 99);
        if (r < 8) send_noise();
        else if (r < 33 && open_depth < 18) push_pattern();
        else if (r < 60 && open_depth < 22) send_beat(CMD_START, random_element());
        else if (open_depth > 0) send_beat(CMD_END, random_element());
        else send_beat(CMD_START, random_element());
      end
      r = $urandom_range(0, 9);
      if (r < 8) begin
        while (open_depth > 0 && !doc_halted) send_beat(CMD_END, random_element());
      end
      if (r >= 6 && r < 8) begin
        // One end too many, then a start that the hold must ignore.
        send_beat(CMD_END, random_element());
        send_beat(CMD_START, random_element());
      end
    end
  endtask

  // A full four-deep path, unwound again, plus the longest-first ordering.
  task automatic test_directed_paths();
    send_beat(CMD_BEGIN, EL_CERT);
    send_beat(CMD_START, EL_RORESP);
    send_beat(CMD_START, EL_RIID);
    send_beat(CMD_START, EL_KEYID);
    send_beat(CMD_START, EL_HASH);
    send_beat(CMD_END, EL_HASH);
    send_beat(CMD_END, EL_KEYID);
    send_beat(CMD_END, EL_RIID);
    send_beat(CMD_END, EL_RORESP);
  endtask

  // Dropped beats, popping an empty stack, the hold, and the depth-one rule.
  task automatic test_special_cases();
    send_beat(CMD_START, CODE_W'(63));
    send_beat(CMD_END, CODE_W'(NUM_ELEMENTS));
    send_beat(CMD_NONE, EL_ROACQ);
    send_beat(CMD_END, EL_SIG);
    send_beat(CMD_START, EL_SIG);
    send_beat(CMD_END, EL_SIG);
    send_beat(CMD_BEGIN, CODE_W'(63));
    // At depth one only the innermost entry of a long pattern is compared.
    send_beat(CMD_START, EL_HASH);
    send_beat(CMD_START, CODE_W'(NUM_ELEMENTS - 1));
    send_beat(CMD_START, EL_CERT);
    send_beat(CMD_END, EL_CERT);
    send_beat(CMD_BEGIN, EL_CERT);
  endtask

  task automatic test_random_documents(input int target);
    int goal;
    bit paused;
    goal   = fed_items + target;
    paused = 1'b0;
    while (fed_items < goal) begin
      run_document();
      if (!paused && fed_items >= goal - target / 2) begin
        wait_for_reports();
        paused = 1'b1;
      end
    end
  endtask

  // Receiver: keeps a stall style for a random stretch, then picks another.
  initial begin
    ready_mode_t mode;
    int          left;
    m_tready = 1'b0;
    mode     = RDY_ALWAYS;
    left     = 0;
    forever begin
      @(negedge clk);
      if (left == 0) begin
        mode = ready_mode_t'($urandom_range(0, 3));
        left = $urandom_range(5, 60);
      end
      left--;
      case (mode)
        RDY_ALWAYS: m_tready = 1'b1;
        RDY_MOSTLY: m_tready = ($urandom_range(0, 3) != 0);
        RDY_RARELY: m_tready = ($urandom_range(0, 3) == 0);
        default:    m_tready = ~m_tready;
      endcase
    end
  end

  // Each result beat is checked field by field against the oldest expectation.
  always @(posedge clk) begin
    context_report_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_reports.size() == 0) begin
        report_mismatch("result beat with nothing expected, context_code",
                        m_tdata[5:0], 0);
      end else begin
        want = expected_reports.pop_front();
        if (m_tuser[0] !== want.kind) report_mismatch("event_kind", m_tuser[0], want.kind);
        if (m_tdata[5:0] !== want.ctx) report_mismatch("context_code", m_tdata[5:0], want.ctx);
        if (m_tdata[10:6] !== want.depth) begin
          report_mismatch("nest_depth", m_tdata[10:6], want.depth);
        end
        if (m_tdata[12:11] !== want.err) begin
          report_mismatch("error_code", m_tdata[12:11], want.err);
        end
      end
    end
  end

  // Watchdog: the run is stuck if no beat moves on either side for too long.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
      else quiet++;
    end
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    rst        = 1'b1;
    s_tvalid   = 1'b0;
    s_tdata    = '0;
    s_tuser    = CMD_BEGIN;
    open_depth = 0;
    doc_halted = 1'b0;
    fail_count = 0;
    fed_items  = 0;
    burst_left = 0;
    for (int i = 0; i < STACK_DEPTH; i++) open_elems[i] = '0;
    repeat (4) @(negedge clk);
    rst = 1'b0;

    test_directed_paths();
    wait_for_reports();
    test_special_cases();
    wait_for_reports();
    test_random_documents(RANDOM_ITEMS);
    wait_for_reports();

    if (expected_reports.size() != 0) begin
      report_mismatch("results never delivered", expected_reports.size(), 0);
    end
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
